// ===== sv/sha1he_pkg.sv =====
// sha1 hash engine package: shared types, constants and round helpers
// used by the interfaces, the message schedule and the top level

package sha1he_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  word_idx_t;
  typedef logic [5:0]  fill_t;
  typedef logic [6:0]  round_t;
  typedef logic [63:0] bit_len_t;

  localparam int NUM_WORDS = 5;
  localparam int NUM_ROUNDS = 80;
  localparam int SCHED_WORDS = 16;

  localparam word_idx_t LAST_WORD_IDX = word_idx_t'(NUM_WORDS - 1);
  localparam round_t LAST_ROUND = round_t'(NUM_ROUNDS - 1);
  localparam fill_t LAST_FILL = 6'd63;
  localparam fill_t LEN_FILL = 6'd56;
  localparam byte_t PAD_MARK = 8'h80;
  localparam bit_len_t BYTE_BITS = 64'd8;

  localparam word_t INIT_CHAIN [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  shift_byte;
    logic  shift_word;
    byte_t data;
  } sched_ctl_t;

  function automatic word_t rotl1(input word_t x);
    return {x[30:0], x[31]};
  endfunction

  function automatic word_t rotl5(input word_t x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic word_t rotl30(input word_t x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

// ===== sv/sha1he_ifs.sv =====
// request channel interfaces of the sha1 hash engine
// depends on sha1he_pkg for payload types

interface sha1he_in_if;
  logic                valid;
  logic                ready;
  sha1he_pkg::byte_t   message_byte;
  logic                byte_present;
  logic                end_of_message;

  modport source (output valid, message_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1he_out_if;
  logic                  valid;
  logic                  ready;
  sha1he_pkg::word_t     digest_word;
  sha1he_pkg::word_idx_t word_number;
  logic                  last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== sv/sha1he_sched.sv =====
// sha1 message block buffer and schedule: a 16-word shift line that takes
// bytes while a block fills and expands the schedule one word per round
// depends on sha1he_pkg

module sha1he_sched (
  input  logic                   clk,
  input  sha1he_pkg::sched_ctl_t ctl,
  output sha1he_pkg::word_t      w
);
  import sha1he_pkg::*;

  localparam int LINE_BITS = SCHED_WORDS * 32;

  logic [LINE_BITS-1:0] line;
  word_t                w_next;

  // word k of the line sits at bits [LINE_BITS-1-32k -: 32]
  assign w = line[LINE_BITS-1 -: 32];
  assign w_next = rotl1(line[LINE_BITS-1-32*13 -: 32] ^ line[LINE_BITS-1-32*8 -: 32] ^
                        line[LINE_BITS-1-32*2 -: 32] ^ line[LINE_BITS-1 -: 32]);

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      line <= {line[LINE_BITS-9:0], ctl.data};
    end else if (ctl.shift_word) begin
      line <= {line[LINE_BITS-33:0], w_next};
    end
  end

endmodule

// ===== sv/sha1_hash_engine_unit.sv =====
// sha1 hash engine top level: byte intake, padding sequencer, shared round unit
// depends on sha1he_pkg, sha1he_ifs and sha1he_sched
//
// One request carries at most one message byte. The 64th byte of a block
// starts the compression: every round through one shared round adder, then
// a fold of the result into the chaining words. The final request starts
// padding, which shifts one pad or length byte per cycle (up to two blocks
// of padding and compression), after which the five digest words leave one
// per cycle as the sink takes them. No request is taken while a block
// compresses, padding runs or the digest is being delivered.

module sha1_hash_engine_unit (
  input  logic clk,
  input  logic rst,
  sha1he_in_if.sink    msg,
  sha1he_out_if.source digest
);
  import sha1he_pkg::*;

  state_t     state;
  state_t     state_next;
  sched_ctl_t ctl;
  word_t      w;

  word_t      chain [NUM_WORDS];
  word_t      ra, rb, rc, rd, re;
  word_t      f, k, tmp;
  fill_t      fill_count;
  bit_len_t   bit_length;
  round_t     rnd;
  word_idx_t  word_idx;
  logic       in_pad;
  logic       pad_first;
  logic       pad_len;
  logic       pend_end;
  byte_t      pad_byte;
  logic       accept;
  logic       out_take;

  sha1he_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  assign accept = msg.valid && msg.ready;
  assign out_take = digest.valid && digest.ready;

  assign digest.digest_word = chain[word_idx];
  assign digest.word_number = word_idx;
  assign digest.last_word = (word_idx == LAST_WORD_IDX);

  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (pad_len && fill_count >= LEN_FILL) begin
      pad_byte = bit_length[{~fill_count[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    if (rnd < 7'd20) begin
      f = (rb & rc) | (~rb & rd);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = rb ^ rc ^ rd;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (rb & rc) | (rb & rd) | (rc & rd);
      k = K2;
    end else begin
      f = rb ^ rc ^ rd;
      k = K3;
    end
    tmp = rotl5(ra) + f + re + k + w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    msg.ready = 1'b0;
    digest.valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg.ready = 1'b1;
        if (msg.valid) begin
          if (msg.byte_present) begin
            ctl.shift_byte = 1'b1;
            ctl.data = msg.message_byte;
            if (fill_count == LAST_FILL) begin
              state_next = ST_ROUND;
            end else if (msg.end_of_message) begin
              state_next = ST_PAD;
            end
          end else if (msg.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.data = pad_byte;
        if (fill_count == LAST_FILL) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.shift_word = 1'b1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (in_pad) begin
          state_next = pad_len ? ST_OUT : ST_PAD;
        end else begin
          state_next = pend_end ? ST_PAD : ST_IDLE;
        end
      end
      ST_OUT: begin
        digest.valid = 1'b1;
        if (digest.ready && word_idx == LAST_WORD_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_CHAIN;
      fill_count <= '0;
      bit_length <= '0;
      rnd <= '0;
      word_idx <= '0;
      in_pad <= 1'b0;
      pad_first <= 1'b0;
      pad_len <= 1'b0;
      pend_end <= 1'b0;
    end else begin
      if (ctl.shift_byte) begin
        fill_count <= fill_count + 6'd1;
      end
      if (accept) begin
        pend_end <= msg.end_of_message;
        if (msg.byte_present) begin
          bit_length <= bit_length + BYTE_BITS;
        end
      end
      if (!in_pad && state_next == ST_PAD) begin
        in_pad <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (pad_first) begin
          pad_len <= (fill_count < LEN_FILL);
        end
      end
      if (state != ST_ROUND && state_next == ST_ROUND) begin
        rnd <= '0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 7'd1;
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= chain[i] + ((i == 0) ? ra : (i == 1) ? rb : (i == 2) ? rc :
                                  (i == 3) ? rd : re);
        end
        if (in_pad && !pad_len) begin
          pad_len <= 1'b1;
        end
      end
      if (out_take) begin
        if (word_idx == LAST_WORD_IDX) begin
          word_idx <= '0;
          chain <= INIT_CHAIN;
          fill_count <= '0;
          bit_length <= '0;
          in_pad <= 1'b0;
          pad_len <= 1'b0;
          pend_end <= 1'b0;
        end else begin
          word_idx <= word_idx + 3'd1;
        end
      end
    end
  end

  // working variables a..e
  always_ff @(posedge clk) begin
    if (state != ST_ROUND && state_next == ST_ROUND) begin
      ra <= chain[0];
      rb <= chain[1];
      rc <= chain[2];
      rd <= chain[3];
      re <= chain[4];
    end else if (state == ST_ROUND) begin
      re <= rd;
      rd <= rc;
      rc <= rotl30(rb);
      rb <= ra;
      ra <= tmp;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("request taken while digest pending");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> rnd <= LAST_ROUND)
    else $error("round counter out of range");

  a_out_block_aligned: assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> fill_count == '0 && pad_len)
    else $error("digest out before length block");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_take && word_idx == LAST_WORD_IDX |=>
      bit_length == '0 && fill_count == '0 && chain[0] == INIT_CHAIN[0] && !in_pad)
    else $error("state not restored after digest");

  a_pad_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD && pad_first |-> $past(state) != ST_PAD)
    else $error("pad mark issued twice");

endmodule

// ===== bench/tb.sv =====
// testbench for sha1_hash_engine_unit: byte messages in, five digest words out per message
// depends on sha1he_pkg and sha1he_ifs; expected digests come from a sha-1 model kept in here

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1he_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    word_t     dw;
    word_idx_t idx;
    logic      lw;
  } digest_exp_t;

  logic clk;
  logic rst;

  sha1he_in_if  msg_ch ();
  sha1he_out_if digest_ch ();

  sha1_hash_engine_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch)
  );

  word_t         chain_h [NUM_WORDS];
  byte_t         blk_bytes [64];
  int unsigned   fill_n;
  bit_len_t      msg_bits;
  digest_exp_t   pending_digest [$];

  int            err_count = 0;
  int            sent_items;
  int            send_idle_pct;
  int            stall_pct;
  int            quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t rol32(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_compress_block();
    word_t sched [16];
    word_t a, b, c, d, e, f, k, sum;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r >= 16)
        sched[r % 16] = rol32(sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
                              sched[(r + 2) % 16] ^ sched[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      sum = rol32(a, 5) + f + e + k + sched[r % 16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_restart();
    chain_h = INIT_CHAIN;
    fill_n = 0;
    msg_bits = '0;
  endfunction

  // fold one accepted request into the running hash, queue the digest on the end
  function automatic void sha1_absorb(input byte_t b, input logic present, input logic is_end);
    digest_exp_t exp_word;
    if (present) begin
      blk_bytes[fill_n] = b;
      msg_bits += BYTE_BITS;
      fill_n++;
      if (fill_n == 64) begin
        sha1_compress_block();
        fill_n = 0;
      end
    end
    if (!is_end)
      return;
    blk_bytes[fill_n] = PAD_MARK;
    fill_n++;
    if (fill_n > LEN_FILL) begin
      while (fill_n < 64) begin
        blk_bytes[fill_n] = 8'h00;
        fill_n++;
      end
      sha1_compress_block();
      fill_n = 0;
    end
    while (fill_n < LEN_FILL) begin
      blk_bytes[fill_n] = 8'h00;
      fill_n++;
    end
    for (int i = 0; i < 8; i++)
      blk_bytes[LEN_FILL + i] = msg_bits[63 - 8*i -: 8];
    sha1_compress_block();
    for (int i = 0; i < NUM_WORDS; i++) begin
      exp_word.dw = chain_h[i];
      exp_word.idx = word_idx_t'(i);
      exp_word.lw = (i == NUM_WORDS - 1);
      pending_digest = {pending_digest, exp_word};
    end
    sha1_restart();
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic push_request(input byte_t b, input logic present, input logic is_end);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.message_byte <= b;
    msg_ch.byte_present <= present;
    msg_ch.end_of_message <= is_end;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    sha1_absorb(b, present, is_end);
    if (present || is_end)
      sent_items++;
  endtask

  // random bytes, a few ignored requests mixed in, end either on the last byte or alone
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        push_request(byte_t'($urandom), 1'b0, 1'b0);
      push_request(byte_t'($urandom), 1'b1, end_on_byte && i == len - 1);
    end
    if (!end_on_byte || len == 0)
      push_request(byte_t'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_for_digest_drain();
    msg_ch.valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    push_request(8'hA5, 1'b0, 1'b0);
    push_request(8'hFF, 1'b0, 1'b1);
    push_request(8'h00, 1'b1, 1'b1);
    push_request(8'hFF, 1'b1, 1'b1);
    push_request(8'h61, 1'b1, 1'b0);
    push_request(8'h5A, 1'b0, 1'b0);
    push_request(8'h62, 1'b1, 1'b0);
    push_request(8'h63, 1'b1, 1'b0);
    push_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_pressure();
    send_idle_pct = 0;
    stall_pct = 64;
    send_message(3, 1'b1);
    wait_for_digest_drain();
    send_message(4, 1'b0);
  endtask

  // one block that just fits, padding spilling into a second block, end on a full block
  task automatic test_block_boundaries();
    send_idle_pct = 0;
    stall_pct = 0;
    send_message(55, 1'b1);
    send_idle_pct = 64;
    send_message(57, 1'b1);
    send_idle_pct = 10;
    stall_pct = 10;
    send_message(64, 1'b1);
  endtask

  task automatic test_random_messages(input int idle_pct, input int stall, input int budget);
    int stop_at;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      if ($urandom_range(9) == 0)
        send_message($urandom_range(13, 30), $urandom_range(1));
      else
        send_message($urandom_range(0, 8), $urandom_range(1));
    end
  endtask

  always @(posedge clk) begin
    digest_exp_t want;
    if (rst) begin
      digest_ch.ready <= 1'b0;
    end else begin
      if (digest_ch.valid && digest_ch.ready) begin
        if (pending_digest.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h", digest_ch.digest_word));
        end else begin
          want = pending_digest.pop_front();
          if (digest_ch.digest_word !== want.dw)
            report_mismatch($sformatf("digest_word %h, want %h", digest_ch.digest_word, want.dw));
          if (digest_ch.word_number !== want.idx)
            report_mismatch($sformatf("word_number %0d, want %0d", digest_ch.word_number,
                                      want.idx));
          if (digest_ch.last_word !== want.lw)
            report_mismatch($sformatf("last_word %b, want %b", digest_ch.last_word, want.lw));
        end
      end
      digest_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sent_items = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    sha1_restart();
    rst <= 1'b1;
    msg_ch.valid <= 1'b0;
    msg_ch.message_byte <= 8'h00;
    msg_ch.byte_present <= 1'b0;
    msg_ch.end_of_message <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_pressure();
    test_block_boundaries();
    test_random_messages(0, 0, 12);
    test_random_messages(64, 0, 12);
    test_random_messages(0, 64, 12);
    test_random_messages(10, 10, 12);

    msg_ch.valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
